// ===== hw/rtl/egb_pkg.sv =====
// Shared constants and types for the extended GCD block.
package egb_pkg;

  localparam int WIDTH_DEF = 32;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_DIV_WAIT,
    ST_FIX,
    ST_SHIFT_B,
    ST_SHIFT_A,
    ST_DONE
  } state_t;

  // Request from the sequencer to the shared divider.
  typedef struct packed {
    logic start;
  } div_req_t;

  // Status from the shared divider back to the sequencer.
  typedef struct packed {
    logic done;
  } div_stat_t;

endpackage

// ===== hw/rtl/egb_divmac.sv =====
// Iterative signed truncating divider that also forms quotient products.
module egb_divmac import egb_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  input  logic [WIDTH-1:0] num,
  input  logic [WIDTH-1:0] den,
  input  logic [WIDTH-1:0] m0,
  input  logic [WIDTH-1:0] m1,
  output div_stat_t        stat,
  output logic [WIDTH-1:0] quo,
  output logic [WIDTH-1:0] rem,
  output logic [WIDTH-1:0] prod0,
  output logic [WIDTH-1:0] prod1
);

  localparam int CW = (WIDTH > 1) ? $clog2(WIDTH) : 1;

  logic             busy_r, busy_nxt;
  logic             done_r, done_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic [WIDTH-1:0] dvd_r, dvd_nxt;
  logic [WIDTH-1:0] part_r, part_nxt;
  logic [WIDTH-1:0] dmag_r, dmag_nxt;
  logic [WIDTH-1:0] acc0_r, acc0_nxt;
  logic [WIDTH-1:0] acc1_r, acc1_nxt;
  logic [WIDTH-1:0] m0_r, m0_nxt;
  logic [WIDTH-1:0] m1_r, m1_nxt;
  logic             nneg_r, nneg_nxt;
  logic             qneg_r, qneg_nxt;

  logic [WIDTH:0]   shifted;
  logic [WIDTH:0]   diff;
  logic             qbit;

  assign shifted = {part_r, dvd_r[WIDTH-1]};
  assign diff    = shifted - {1'b0, dmag_r};
  assign qbit    = ~diff[WIDTH];

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    dvd_nxt  = dvd_r;
    part_nxt = part_r;
    dmag_nxt = dmag_r;
    acc0_nxt = acc0_r;
    acc1_nxt = acc1_r;
    m0_nxt   = m0_r;
    m1_nxt   = m1_r;
    nneg_nxt = nneg_r;
    qneg_nxt = qneg_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CW'(WIDTH - 1);
      dvd_nxt  = num[WIDTH-1] ? (-num) : num;
      dmag_nxt = den[WIDTH-1] ? (-den) : den;
      part_nxt = '0;
      acc0_nxt = '0;
      acc1_nxt = '0;
      m0_nxt   = m0;
      m1_nxt   = m1;
      nneg_nxt = num[WIDTH-1];
      qneg_nxt = num[WIDTH-1] ^ den[WIDTH-1];
    end else if (busy_r) begin
      // Restoring step; products follow the quotient bits in Horner order.
      part_nxt = qbit ? diff[WIDTH-1:0] : shifted[WIDTH-1:0];
      dvd_nxt  = {dvd_r[WIDTH-2:0], qbit};
      acc0_nxt = {acc0_r[WIDTH-2:0], 1'b0} + (qbit ? m0_r : '0);
      acc1_nxt = {acc1_r[WIDTH-2:0], 1'b0} + (qbit ? m1_r : '0);
      cnt_nxt  = cnt_r - CW'(1);
      if (cnt_r == '0) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
    end
    cnt_r  <= cnt_nxt;
    dvd_r  <= dvd_nxt;
    part_r <= part_nxt;
    dmag_r <= dmag_nxt;
    acc0_r <= acc0_nxt;
    acc1_r <= acc1_nxt;
    m0_r   <= m0_nxt;
    m1_r   <= m1_nxt;
    nneg_r <= nneg_nxt;
    qneg_r <= qneg_nxt;
  end

  assign stat.done = done_r;
  assign quo   = qneg_r ? (-dvd_r) : dvd_r;
  assign rem   = nneg_r ? (-part_r) : part_r;
  assign prod0 = qneg_r ? (-acc0_r) : acc0_r;
  assign prod1 = qneg_r ? (-acc1_r) : acc1_r;

endmodule

// ===== hw/rtl/extended_gcd_bezout.sv =====
// Top level of the extended GCD block: sequencer around one shared divider.
//
//   channel  direction  ports                                    handshake
//   in       input      in_a, in_b, in_want_nonzero_first        in_valid / in_ready
//   out      output     out_coef_a, out_coef_b, out_divisor      out_valid / out_ready
//
// Each Euclid step is one pass of the shared divider: a start from ST_CHECK,
// WIDTH restoring steps and an update in ST_DIV_WAIT. When the first
// coefficient must be moved off zero, further passes divide b and then a by the divisor.
// The block takes one word at a time; in_ready is high only while idle.
// A finished word waits in the output register while out_ready is low; the
// next input word may be taken meanwhile and holds in its last state until
// the output register frees up.
// Reset is synchronous and active low and clears only control state.
module extended_gcd_bezout import egb_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_valid,
  output logic             in_ready,
  input  logic [WIDTH-1:0] in_a,
  input  logic [WIDTH-1:0] in_b,
  input  logic             in_want_nonzero_first,
  output logic             out_valid,
  input  logic             out_ready,
  output logic [WIDTH-1:0] out_coef_a,
  output logic [WIDTH-1:0] out_coef_b,
  output logic [WIDTH-1:0] out_divisor
);

  state_t state_r, state_nxt;

  // Operand and Euclid recurrence registers.
  logic [WIDTH-1:0] a_r, a_nxt;
  logic [WIDTH-1:0] b_r, b_nxt;
  logic             want_r, want_nxt;
  logic             swap_r, swap_nxt;
  logic [WIDTH-1:0] num_r, num_nxt;
  logic [WIDTH-1:0] den_r, den_nxt;
  logic [WIDTH-1:0] p0_r, p0_nxt;
  logic [WIDTH-1:0] p1_r, p1_nxt;
  logic [WIDTH-1:0] r0_r, r0_nxt;
  logic [WIDTH-1:0] r1_r, r1_nxt;
  logic [WIDTH-1:0] ca_r, ca_nxt;
  logic [WIDTH-1:0] cb_r, cb_nxt;
  logic [WIDTH-1:0] bq_r, bq_nxt;

  // Output register.
  logic             ovld_r, ovld_nxt;
  logic [WIDTH-1:0] oca_r, oca_nxt;
  logic [WIDTH-1:0] ocb_r, ocb_nxt;
  logic [WIDTH-1:0] og_r, og_nxt;

  // Divider connections.
  div_req_t         dreq;
  div_stat_t        dstat;
  logic [WIDTH-1:0] d_num, d_den, d_m0, d_m1;
  logic [WIDTH-1:0] d_quo, d_rem, d_prod0, d_prod1;

  // Helpers for the end-of-loop fixups.
  logic [WIDTH:0]   g_ext;
  logic [WIDTH:0]   neg_a_ext;
  logic [WIDTH-1:0] ca_pick, cb_pick;

  assign g_ext     = {num_r[WIDTH-1], num_r};
  // The negation is one bit wider so that the most negative a is not
  // mistaken for its own negative.
  assign neg_a_ext = -{a_r[WIDTH-1], a_r};

  egb_divmac #(.WIDTH(WIDTH)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (dreq),
    .num   (d_num),
    .den   (d_den),
    .m0    (d_m0),
    .m1    (d_m1),
    .stat  (dstat),
    .quo   (d_quo),
    .rem   (d_rem),
    .prod0 (d_prod0),
    .prod1 (d_prod1)
  );

  always_comb begin
    state_nxt = state_r;
    a_nxt     = a_r;
    b_nxt     = b_r;
    want_nxt  = want_r;
    swap_nxt  = swap_r;
    num_nxt   = num_r;
    den_nxt   = den_r;
    p0_nxt    = p0_r;
    p1_nxt    = p1_r;
    r0_nxt    = r0_r;
    r1_nxt    = r1_r;
    ca_nxt    = ca_r;
    cb_nxt    = cb_r;
    bq_nxt    = bq_r;
    ovld_nxt  = ovld_r & ~out_ready;
    oca_nxt   = oca_r;
    ocb_nxt   = ocb_r;
    og_nxt    = og_r;
    dreq.start = 1'b0;
    d_num     = num_r;
    d_den     = den_r;
    d_m0      = p1_r;
    d_m1      = r1_r;
    in_ready  = (state_r == ST_IDLE);
    ca_pick   = swap_r ? r0_r : p0_r;
    cb_pick   = swap_r ? p0_r : r0_r;

    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          // The larger operand in signed order is the first dividend.
          a_nxt    = in_a;
          b_nxt    = in_b;
          want_nxt = in_want_nonzero_first;
          swap_nxt = ($signed(in_a) < $signed(in_b));
          num_nxt  = swap_nxt ? in_b : in_a;
          den_nxt  = swap_nxt ? in_a : in_b;
          p0_nxt   = WIDTH'(1);
          p1_nxt   = '0;
          r0_nxt   = '0;
          r1_nxt   = WIDTH'(1);
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        if (den_r == '0) begin
          state_nxt = ST_FIX;
        end else begin
          dreq.start = 1'b1;
          state_nxt  = ST_DIV_WAIT;
        end
      end
      ST_DIV_WAIT: begin
        if (dstat.done) begin
          p0_nxt  = p1_r;
          p1_nxt  = p0_r - d_prod0;
          r0_nxt  = r1_r;
          r1_nxt  = r0_r - d_prod1;
          num_nxt = den_r;
          den_nxt = d_rem;
          state_nxt = ST_CHECK;
        end
      end
      ST_FIX: begin
        // num_r now holds the divisor. Both special cases are tested in
        // order, so the second one wins when a and the divisor are zero.
        ca_nxt = ca_pick;
        cb_nxt = cb_pick;
        if (num_r == a_r) begin
          ca_nxt = WIDTH'(1);
          cb_nxt = '0;
        end
        if (g_ext == neg_a_ext) begin
          ca_nxt = '1;
          cb_nxt = '0;
        end
        if (want_r && (ca_nxt == '0) && (num_r != '0)) begin
          state_nxt = ST_SHIFT_B;
          dreq.start = 1'b1;
          d_num = b_r;
          d_den = num_r;
          d_m0  = '0;
          d_m1  = '0;
        end else begin
          state_nxt = ST_DONE;
        end
      end
      ST_SHIFT_B: begin
        d_num = b_r;
        d_den = num_r;
        d_m0  = '0;
        d_m1  = '0;
        if (dstat.done) begin
          bq_nxt = d_quo;
          dreq.start = 1'b1;
          d_num = a_r;
          state_nxt = ST_SHIFT_A;
        end
      end
      ST_SHIFT_A: begin
        d_num = a_r;
        d_den = num_r;
        d_m0  = '0;
        d_m1  = '0;
        if (dstat.done) begin
          // Step along the solution line; direction from the sign of coef_b.
          if (!cb_r[WIDTH-1] && (cb_r != '0)) begin
            ca_nxt = ca_r + bq_r;
            cb_nxt = cb_r - d_quo;
          end else begin
            ca_nxt = ca_r - bq_r;
            cb_nxt = cb_r + d_quo;
          end
          state_nxt = ST_DONE;
        end
      end
      ST_DONE: begin
        if (!ovld_r || out_ready) begin
          ovld_nxt  = 1'b1;
          oca_nxt   = ca_r;
          ocb_nxt   = cb_r;
          og_nxt    = num_r;
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      ovld_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      ovld_r  <= ovld_nxt;
    end
    a_r    <= a_nxt;
    b_r    <= b_nxt;
    want_r <= want_nxt;
    swap_r <= swap_nxt;
    num_r  <= num_nxt;
    den_r  <= den_nxt;
    p0_r   <= p0_nxt;
    p1_r   <= p1_nxt;
    r0_r   <= r0_nxt;
    r1_r   <= r1_nxt;
    ca_r   <= ca_nxt;
    cb_r   <= cb_nxt;
    bq_r   <= bq_nxt;
    oca_r  <= oca_nxt;
    ocb_r  <= ocb_nxt;
    og_r   <= og_nxt;
  end

  assign out_valid   = ovld_r;
  assign out_coef_a  = oca_r;
  assign out_coef_b  = ocb_r;
  assign out_divisor = og_r;

endmodule

// ===== hw/rtl/egb_checker.sv =====
// Port-level checker for the extended GCD block, bound to the top level.
module egb_checker import egb_pkg::*; #(
  parameter int WIDTH = WIDTH_DEF
) (
  input logic             clk,
  input logic             rst_n,
  input logic             in_valid,
  input logic             in_ready,
  input logic [WIDTH-1:0] in_a,
  input logic [WIDTH-1:0] in_b,
  input logic             in_want_nonzero_first,
  input logic             out_valid,
  input logic             out_ready,
  input logic [WIDTH-1:0] out_coef_a,
  input logic [WIDTH-1:0] out_coef_b,
  input logic [WIDTH-1:0] out_divisor
);

  // A waiting result word holds still.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_coef_a) &&
      $stable(out_coef_b) && $stable(out_divisor))
    else $error("result word changed while stalled");

  // One word at a time: the block is busy right after it takes a word.
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("input taken while busy");

  // A waiting input word holds still until it is taken.
  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_ready |=> in_valid && $stable(in_a) && $stable(in_b) &&
      $stable(in_want_nonzero_first))
    else $error("input word changed while waiting");

  // A zero divisor only comes from zero operands, with coef_b zero.
  a_zero_g: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_divisor == '0) |-> (out_coef_b == '0))
    else $error("zero divisor with nonzero coef_b");

endmodule

bind extended_gcd_bezout egb_checker #(.WIDTH(WIDTH)) u_egb_checker (.*);

// ===== tb/sv/testbench.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the extended GCD block with a built-in predictor.
module testbench;
  import egb_pkg::*;

  localparam int W = WIDTH_DEF;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic [W-1:0] in_a = '0;
  logic [W-1:0] in_b = '0;
  logic in_want_nonzero_first = 1'b0;
  logic out_valid;
  logic out_ready = 1'b0;
  logic [W-1:0] out_coef_a;
  logic [W-1:0] out_coef_b;
  logic [W-1:0] out_divisor;

  // One expected result word.
  typedef struct packed {
    logic [W-1:0] coef_a;
    logic [W-1:0] coef_b;
    logic [W-1:0] divisor;
  } bezout_t;

  bezout_t bezout_q[$];
  int unsigned error_count = 0;
  // Idle percentages for the sender and the receiver, set per phase.
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  // When nonzero, the receiver holds out_ready low while this counts down to zero.
  int unsigned hold_off_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  extended_gcd_bezout #(.WIDTH(W)) i_dut (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .in_a(in_a),
    .in_b(in_b),
    .in_want_nonzero_first(in_want_nonzero_first),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_coef_a(out_coef_a),
    .out_coef_b(out_coef_b),
    .out_divisor(out_divisor)
  );

  // Truncating division and remainder on 64-bit two's complement values,
  // done on magnitudes so the most negative operand behaves as wrapped math.
  function automatic logic [63:0] mag64(logic [63:0] v);
    return v[63] ? -v : v;
  endfunction

  function automatic logic [63:0] tquot(logic [63:0] n, logic [63:0] d);
    logic [63:0] q;
    q = mag64(n) / mag64(d);
    return (n[63] != d[63]) ? -q : q;
  endfunction

  function automatic logic [63:0] trem(logic [63:0] n, logic [63:0] d);
    logic [63:0] r;
    r = mag64(n) % mag64(d);
    return n[63] ? -r : r;
  endfunction

  // Computes the Bezout triple the block must return for one input word.
  function automatic bezout_t bezout_solve(logic [W-1:0] a_in, logic [W-1:0] b_in,
                                           logic want);
    logic [63:0] a, b, num, den, q, rem, p0, p1, r0, r1, np, nr, ca, cb, g, bq, aq;
    logic swapped;
    bezout_t res;
    a = 64'(signed'(a_in));
    b = 64'(signed'(b_in));
    // The larger operand, by signed compare, is the first dividend.
    swapped = $signed(a) < $signed(b);
    num = swapped ? b : a;
    den = swapped ? a : b;
    p0 = 64'd1; p1 = 64'd0; r0 = 64'd0; r1 = 64'd1;
    while (den != 0) begin
      q = tquot(num, den);
      rem = trem(num, den);
      np = p0 - q * p1;
      nr = r0 - q * r1;
      p0 = p1; p1 = np;
      r0 = r1; r1 = nr;
      num = den;
      den = rem;
    end
    g = num;
    ca = swapped ? r0 : p0;
    cb = swapped ? p0 : r0;
    if (g == a) begin
      ca = 64'd1;
      cb = 64'd0;
    end
    if (g == -a) begin
      ca = -64'd1;
      cb = 64'd0;
    end
    ca = 64'(signed'(ca[W-1:0]));
    cb = 64'(signed'(cb[W-1:0]));
    // Step along the solution line when a nonzero first coefficient is wanted but ca is zero.
    if (want && ca == 0 && g != 0) begin
      bq = tquot(b, g);
      aq = tquot(a, g);
      if (!cb[63] && cb != 0) begin
        ca = ca + bq;
        cb = cb - aq;
      end else begin
        ca = ca - bq;
        cb = cb + aq;
      end
    end
    res.coef_a = ca[W-1:0];
    res.coef_b = cb[W-1:0];
    res.divisor = g[W-1:0];
    return res;
  endfunction

  // Sends one word, with a random idle gap first, and queues its expected result.
  // The valid line is dropped here only when an idle gap follows an accepted word.
  task automatic send_word(logic [W-1:0] a, logic [W-1:0] b, logic want);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_a <= a;
    in_b <= b;
    in_want_nonzero_first <= want;
    bezout_q.insert(bezout_q.size(), bezout_solve(a, b, want));
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Counts down the long receiver hold-off.
  always @(posedge clk) begin
    if (hold_off_cycles != 0) begin
      hold_off_cycles <= hold_off_cycles - 1;
    end
  end

  // Receiver: random stalls, plus an optional long hold-off.
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
    end else if (hold_off_cycles != 0) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99, 0) >= recv_stall_pct);
    end
  end

  // Checks every accepted result word against the oldest expectation.
  always @(posedge clk) begin
    bezout_t exp_word;
    if (rst_n && out_valid && out_ready) begin
      if (bezout_q.size() == 0) begin
        $error("unexpected word: coef_a=%0d coef_b=%0d divisor=%0d",
               $signed(out_coef_a), $signed(out_coef_b), $signed(out_divisor));
        error_count++;
      end else begin
        exp_word = bezout_q.pop_front();
        if (out_coef_a !== exp_word.coef_a) begin
          $error("coef_a: expected %0d, actual %0d", $signed(exp_word.coef_a),
                 $signed(out_coef_a));
          error_count++;
        end
        if (out_coef_b !== exp_word.coef_b) begin
          $error("coef_b: expected %0d, actual %0d", $signed(exp_word.coef_b),
                 $signed(out_coef_b));
          error_count++;
        end
        if (out_divisor !== exp_word.divisor) begin
          $error("divisor: expected %0d, actual %0d", $signed(exp_word.divisor),
                 $signed(out_divisor));
          error_count++;
        end
      end
    end
  end

  function automatic logic [W-1:0] rand_operand();
    logic [W-1:0] v;
    case ($urandom_range(5, 0))
      0: v = W'($urandom_range(20, 0));
      1: v = -W'($urandom_range(20, 0));
      2: v = W'($urandom_range(3000, 0)) * W'($urandom_range(300, 1));
      3: v = W'($urandom) & W'(32'h0000_ffff);
      default: v = W'($urandom);
    endcase
    return v;
  endfunction

  // Extremes, zeros, equal and opposite operands, and the special sign cases.
  task automatic test_directed();
    logic [W-1:0] max_pos, min_neg;
    max_pos = {1'b0, {(W-1){1'b1}}};
    min_neg = {1'b1, {(W-1){1'b0}}};
    send_word('0, '0, 1'b0);
    send_word('0, '0, 1'b1);
    send_word(max_pos, -max_pos, 1'b1);
    send_word(-max_pos, max_pos, 1'b0);
    send_word(max_pos, max_pos - 1, 1'b1);
    send_word(min_neg, W'(6), 1'b1);
    send_word(W'(6), min_neg, 1'b0);
    send_word(min_neg, min_neg, 1'b1);
    send_word(W'(12), W'(18), 1'b0);
    send_word(W'(12), W'(18), 1'b1);
    send_word(W'(18), W'(6), 1'b1);
    send_word(-W'(18), W'(6), 1'b1);
    send_word(W'(6), -W'(18), 1'b1);
    send_word(W'(7), '0, 1'b1);
    send_word('0, -W'(7), 1'b1);
    send_word(W'(5), W'(5), 1'b1);
    send_word(W'(5), -W'(5), 1'b0);
    send_word(-W'(1), W'(1), 1'b1);
    send_word(W'(1_836_311_903), W'(1_134_903_170), 1'b0);
    send_word(-W'(1_836_311_903), W'(1_134_903_170), 1'b1);
    send_word(W'(32'h5555_5555), W'(32'h2aaa_aaaa), 1'b1);
  endtask

  task automatic test_random(int unsigned count);
    logic [W-1:0] a, b;
    repeat (count) begin
      a = rand_operand();
      b = rand_operand();
      // Often make one operand a multiple of the other to hit the shift path.
      if ($urandom_range(3, 0) == 0) b = a * W'($urandom_range(9, 0));
      send_word(a, b, 1'($urandom));
    end
  endtask

  // Receiver holds off while the sender keeps offering, so the block stalls.
  task automatic test_backpressure();
    hold_off_cycles = 4000;
    test_random(6);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (bezout_q.size() != 0) @(posedge clk);
    repeat (300) @(posedge clk);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    drain();
    test_backpressure();
    drain();
    send_idle_pct = 0; recv_stall_pct = 0;
    test_random(150);
    send_idle_pct = 79; recv_stall_pct = 0;
    test_random(140);
    send_idle_pct = 0; recv_stall_pct = 79;
    test_random(140);
    send_idle_pct = 23; recv_stall_pct = 23;
    test_random(140);
    drain();
    if (error_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  // Worst case is roughly 48 divider passes per word, plus receiver stalls;
  // this bound leaves a wide margin over that.
  initial begin
    #40_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

// ===== filelist.f =====
hw/rtl/egb_pkg.sv
hw/rtl/egb_divmac.sv
hw/rtl/extended_gcd_bezout.sv
hw/rtl/egb_checker.sv
tb/sv/testbench.sv
